/* rtl/shell_command_tokenizer_defines.svh */
`ifndef SHELL_COMMAND_TOKENIZER_DEFINES_SVH
`define SHELL_COMMAND_TOKENIZER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sct_pkg.sv */
package sct_pkg;

    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_TOKEN   = 3'b010,
        MODE_COMMENT = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        PFX_NONE = 3'd0,
        PFX_LT   = 3'd1,
        PFX_GT   = 3'd2,
        PFX_GG   = 3'd3,
        PFX_GA   = 3'd4,
        PFX_GGA  = 3'd5,
        PFX_AMP  = 3'd6,
        PFX_BAR  = 3'd7
    } t_prefix;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_mode   mode;
        t_prefix prefix;
        t_quote  quote;
        logic    esc;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode: MODE_IDLE, prefix: PFX_NONE, quote: QUOTE_NONE, esc: 1'b0
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] text_byte;
        logic [4:0] token_type;
        logic       error;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_result_list;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_out_word;

    // token types
    localparam logic [4:0] TT_SIMPLE   = 5'd0;
    localparam logic [4:0] TT_LT_LT    = 5'd1;
    localparam logic [4:0] TT_LT       = 5'd2;
    localparam logic [4:0] TT_GGA_BANG = 5'd3;
    localparam logic [4:0] TT_GGA      = 5'd4;
    localparam logic [4:0] TT_GG_BANG  = 5'd5;
    localparam logic [4:0] TT_GG       = 5'd6;
    localparam logic [4:0] TT_GA_BANG  = 5'd7;
    localparam logic [4:0] TT_GA       = 5'd8;
    localparam logic [4:0] TT_GT_BANG  = 5'd9;
    localparam logic [4:0] TT_GT       = 5'd10;
    localparam logic [4:0] TT_SEMI     = 5'd11;
    localparam logic [4:0] TT_AND_AND  = 5'd12;
    localparam logic [4:0] TT_AMP      = 5'd13;
    localparam logic [4:0] TT_OR_OR    = 5'd14;
    localparam logic [4:0] TT_BAR_AMP  = 5'd15;
    localparam logic [4:0] TT_BAR      = 5'd16;
    localparam logic [4:0] TT_LPAREN   = 5'd17;
    localparam logic [4:0] TT_RPAREN   = 5'd18;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;

endpackage

/* rtl/sct_in_if.sv */
interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

/* rtl/sct_out_if.sv */
interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [4:0] token_type;
    logic       error;
    logic       last;

    modport source (output valid, output kind, output text_byte, output token_type,
                    output error, output last, input ready);
    modport sink   (input valid, input kind, input text_byte, input token_type,
                    input error, input last, output ready);
endinterface

/* rtl/sct_lexer.sv */
module sct_lexer (
    input  sct_pkg::t_state       i_state,
    input  logic [7:0]            i_ch,
    output sct_pkg::t_result_list o_res,
    output logic [1:0]            o_count,
    output sct_pkg::t_state       o_next
);
    import sct_pkg::*;

    typedef struct packed {
        t_prefix    nxt;
        logic       used;
        logic [4:0] ttype;
    } t_ext;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_meta(input logic [7:0] c);
        return c == CH_LT || c == CH_GT || c == CH_SEMI || c == CH_AMP ||
               c == CH_BAR || c == CH_LPAREN || c == CH_RPAREN;
    endfunction

    function automatic t_result text_res(input logic [7:0] c);
        return '{kind: KIND_TEXT, text_byte: c, token_type: TT_SIMPLE, error: 1'b0};
    endfunction

    function automatic t_result end_res(input logic [4:0] tt);
        return '{kind: KIND_END, text_byte: CH_NUL, token_type: tt, error: 1'b0};
    endfunction

    function automatic t_result line_res(input logic err);
        return '{kind: KIND_LINE, text_byte: CH_NUL, token_type: TT_SIMPLE, error: err};
    endfunction

    // Extend a pending operator; nxt != PFX_NONE means the byte grew it further.
    function automatic t_ext extend(input t_prefix p, input logic [7:0] c);
        t_ext e;
        e = '{nxt: PFX_NONE, used: 1'b0, ttype: TT_SIMPLE};
        unique case (p)
            PFX_LT: begin
                if (c == CH_LT) begin
                    e.used = 1'b1; e.ttype = TT_LT_LT;
                end else begin
                    e.ttype = TT_LT;
                end
            end
            PFX_GT: begin
                if (c == CH_GT) begin
                    e.nxt = PFX_GG;
                end else if (c == CH_AMP) begin
                    e.nxt = PFX_GA;
                end else if (c == CH_BANG) begin
                    e.used = 1'b1; e.ttype = TT_GT_BANG;
                end else begin
                    e.ttype = TT_GT;
                end
            end
            PFX_GG: begin
                if (c == CH_AMP) begin
                    e.nxt = PFX_GGA;
                end else if (c == CH_BANG) begin
                    e.used = 1'b1; e.ttype = TT_GG_BANG;
                end else begin
                    e.ttype = TT_GG;
                end
            end
            PFX_GA: begin
                if (c == CH_BANG) begin
                    e.used = 1'b1; e.ttype = TT_GA_BANG;
                end else begin
                    e.ttype = TT_GA;
                end
            end
            PFX_GGA: begin
                if (c == CH_BANG) begin
                    e.used = 1'b1; e.ttype = TT_GGA_BANG;
                end else begin
                    e.ttype = TT_GGA;
                end
            end
            PFX_AMP: begin
                if (c == CH_AMP) begin
                    e.used = 1'b1; e.ttype = TT_AND_AND;
                end else begin
                    e.ttype = TT_AMP;
                end
            end
            PFX_BAR: begin
                if (c == CH_BAR) begin
                    e.used = 1'b1; e.ttype = TT_OR_OR;
                end else if (c == CH_AMP) begin
                    e.used = 1'b1; e.ttype = TT_BAR_AMP;
                end else begin
                    e.ttype = TT_BAR;
                end
            end
            default: begin
                e.used = 1'b0;
            end
        endcase
        return e;
    endfunction

    t_result_list res;
    logic [1:0]   cnt;
    t_state       nxt;
    t_ext         ext;
    logic         consumed;
    logic         go_idle;
    logic         err;

    always_comb begin
        res      = '0;
        cnt      = 2'd0;
        nxt      = i_state;
        ext      = extend(i_state.prefix, i_ch);
        consumed = 1'b0;
        go_idle  = 1'b0;
        err      = 1'b0;

        if (i_state.mode == MODE_COMMENT) begin
            if (i_ch == CH_NUL) begin
                res[cnt] = line_res(1'b0);
                cnt      = cnt + 2'd1;
                nxt      = STATE_RESET;
            end
        end else begin
            if (i_state.prefix != PFX_NONE) begin
                nxt.prefix = ext.nxt;
                if (ext.nxt == PFX_NONE) begin
                    res[cnt] = end_res(ext.ttype);
                    cnt      = cnt + 2'd1;
                end
                consumed = ext.used || (ext.nxt != PFX_NONE);
            end

            if (!consumed) begin
                if (i_ch == CH_NUL) begin
                    if (i_state.mode == MODE_TOKEN) begin
                        // a trailing backslash is kept as text
                        if (i_state.esc) begin
                            res[cnt] = text_res(CH_BSLASH);
                            cnt      = cnt + 2'd1;
                        end
                        if (i_state.quote != QUOTE_NONE) begin
                            err = 1'b1;
                        end else begin
                            res[cnt] = end_res(TT_SIMPLE);
                            cnt      = cnt + 2'd1;
                        end
                    end
                    res[cnt] = line_res(err);
                    cnt      = cnt + 2'd1;
                    nxt      = STATE_RESET;
                end else if (i_state.mode == MODE_TOKEN) begin
                    if (i_state.esc) begin
                        nxt.esc = 1'b0;
                        if (i_ch == CH_NL) begin
                            // keep the backslash, then the newline ends the token
                            res[cnt] = text_res(CH_BSLASH);
                            cnt      = cnt + 2'd1;
                            res[cnt] = end_res(TT_SIMPLE);
                            cnt      = cnt + 2'd1;
                            nxt.mode = MODE_IDLE;
                        end else begin
                            res[cnt] = text_res(i_ch);
                            cnt      = cnt + 2'd1;
                        end
                    end else if (i_state.quote != QUOTE_NONE) begin
                        if ((i_state.quote == QUOTE_SINGLE && i_ch == CH_SQUOTE) ||
                            (i_state.quote == QUOTE_DOUBLE && i_ch == CH_DQUOTE)) begin
                            nxt.quote = QUOTE_NONE;
                        end else begin
                            res[cnt] = text_res(i_ch);
                            cnt      = cnt + 2'd1;
                        end
                    end else if (i_ch == CH_SQUOTE) begin
                        nxt.quote = QUOTE_SINGLE;
                    end else if (i_ch == CH_DQUOTE) begin
                        nxt.quote = QUOTE_DOUBLE;
                    end else if (i_ch == CH_BSLASH) begin
                        nxt.esc = 1'b1;
                    end else if (is_meta(i_ch) || is_space(i_ch)) begin
                        res[cnt] = end_res(TT_SIMPLE);
                        cnt      = cnt + 2'd1;
                        nxt.mode = MODE_IDLE;
                        go_idle  = 1'b1;
                    end else begin
                        res[cnt] = text_res(i_ch);
                        cnt      = cnt + 2'd1;
                    end
                end else begin
                    go_idle = 1'b1;
                end
            end

            // byte at a token start
            if (go_idle && !is_space(i_ch)) begin
                priority if (i_ch == CH_HASH) begin
                    nxt.mode = MODE_COMMENT;
                end else if (i_ch == CH_LT) begin
                    nxt.prefix = PFX_LT;
                end else if (i_ch == CH_GT) begin
                    nxt.prefix = PFX_GT;
                end else if (i_ch == CH_AMP) begin
                    nxt.prefix = PFX_AMP;
                end else if (i_ch == CH_BAR) begin
                    nxt.prefix = PFX_BAR;
                end else if (i_ch == CH_SEMI) begin
                    res[cnt] = end_res(TT_SEMI);
                    cnt      = cnt + 2'd1;
                end else if (i_ch == CH_LPAREN) begin
                    res[cnt] = end_res(TT_LPAREN);
                    cnt      = cnt + 2'd1;
                end else if (i_ch == CH_RPAREN) begin
                    res[cnt] = end_res(TT_RPAREN);
                    cnt      = cnt + 2'd1;
                end else begin
                    nxt.mode = MODE_TOKEN;
                    if (i_ch == CH_SQUOTE) begin
                        nxt.quote = QUOTE_SINGLE;
                    end else if (i_ch == CH_DQUOTE) begin
                        nxt.quote = QUOTE_DOUBLE;
                    end else if (i_ch == CH_BSLASH) begin
                        nxt.esc = 1'b1;
                    end else begin
                        res[cnt] = text_res(i_ch);
                        cnt      = cnt + 2'd1;
                    end
                end
            end
        end
    end

    assign o_res   = res;
    assign o_count = cnt;
    assign o_next  = nxt;

endmodule

/* rtl/shell_command_tokenizer.sv */
// The first result of a byte is loaded into the output register once the byte is in the input
// register and the output register is free. Throughput: one result per cycle while the output
// is not stalled; a byte keeps the input register until its last result (at most three) loads.
// Reset (synchronous, active low) empties both registers and puts the lexer between tokens.
module shell_command_tokenizer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sct_in_if.sink           i_in,
    sct_out_if.source        o_out
);
    import sct_pkg::*;

    `include "shell_command_tokenizer_defines.svh"

    logic         r_in_valid, n_in_valid;
    logic [7:0]   r_ch;
    t_state       r_state, n_state;
    logic [1:0]   r_idx, n_idx;
    logic         r_out_valid, n_out_valid;
    t_out_word    r_out, n_out;

    t_result_list w_res;
    logic [1:0]   w_count;
    t_state       w_next;
    logic         w_out_free;
    logic         w_load;
    logic         w_is_last;
    logic         w_done;
    logic         w_in_take;

    sct_lexer u_lexer (
        .i_state (r_state),
        .i_ch    (r_ch),
        .o_res   (w_res),
        .o_count (w_count),
        .o_next  (w_next)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_is_last  = (r_idx == w_count - 2'd1);
    assign w_load     = r_in_valid && (w_count != 2'd0) && w_out_free;
    assign w_done     = r_in_valid && ((w_count == 2'd0) || (w_out_free && w_is_last));
    assign w_in_take  = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (w_done) begin
            n_in_valid = 1'b0;
            n_state    = w_next;
        end
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_out.res    = w_res[r_idx];
            n_out.last   = w_is_last;
            n_idx        = w_is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the byte until all its results have been loaded into the output register
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_ch <= i_in.ch;
        end
        r_out <= n_out;
    end

    assign i_in.ready       = !r_in_valid || w_done;
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.res.kind;
    assign o_out.text_byte  = r_out.res.text_byte;
    assign o_out.token_type = r_out.res.token_type;
    assign o_out.error      = r_out.res.error;
    assign o_out.last       = r_out.last;

    `SCT_ASSERT_NOW(a_idx_in_range, r_in_valid, (r_idx < w_count) || (r_idx == 2'd0), "result index past the last result of the word")
    `SCT_ASSERT_NOW(a_line_is_last, o_out.valid && (o_out.kind == KIND_LINE), o_out.last, "line end not marked last")
    `SCT_ASSERT_NEXT(a_line_resets, w_load && (w_res[r_idx].kind == KIND_LINE), r_state == STATE_RESET, "lexer state not cleared after line end")
    `SCT_ASSERT_NOW(a_comment_no_prefix, r_state.mode == MODE_COMMENT, r_state.prefix == PFX_NONE, "operator pending inside a comment")

endmodule
